### hw/rtl/fintd_pkg.sv
// Package for the FINS/TCP frame deframer: payload structs, header constants
// and the event code passed from the parser to the output stage.
// No dependencies.
package fintd_pkg;

   localparam int LenWidthDefault = 16;
   localparam int HeaderBytes     = 8;
   localparam int HeaderIdxWidth  = $clog2(HeaderBytes);

   localparam logic [15:0] MaxPayloadReset = 16'd1016;

   // Header magic "FINS".
   localparam logic [7:0] Magic0 = 8'h46;
   localparam logic [7:0] Magic1 = 8'h49;
   localparam logic [7:0] Magic2 = 8'h4E;
   localparam logic [7:0] Magic3 = 8'h53;

   localparam logic ErrBadMagic = 1'b0;
   localparam logic ErrTooLong  = 1'b1;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       chunk_end;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       frame_last;
      logic       frame_error;
      logic       error_kind;
   } rsp_type;

   typedef logic [HeaderBytes-1:0][7:0] header_type;

   typedef enum logic [1:0] {
      EV_NONE   = 2'd0,
      EV_BYTE   = 2'd1,
      EV_ERROR  = 2'd2,
      EV_HEADER = 2'd3
   } event_kind_type;

   // For EV_HEADER, last marks a zero-length frame.
   typedef struct packed {
      event_kind_type kind;
      logic [7:0]     data;
      logic           last;
      logic           error_kind;
   } event_type;

endpackage

### hw/rtl/fins_tcp_frame_deframer_unit.sv
// Channel  Direction  Handshake          Payload
// req      in         req_valid/ready    req_type: data_byte, chunk_end
// rsp      out        rsp_valid/ready    rsp_type: out_byte, frame_last, frame_error, error_kind
// csr      in         csr_wr_en          csr_wr_data: max_payload, 16 bits
//
// Each received byte waits in the input register while the parser works on it, and its
// result is then registered in the output register; one byte per cycle is taken while
// rsp is ready and no header is being replayed.
// A good header gives eight items from the output register; while the header store is read
// back no item is taken, so req_ready is low once one waits. Reset is synchronous and needs no
// clearing pass. A stall on rsp holds the result and back-pressures req after one item.
// Depends on fintd_pkg, fintd_in_stage, fintd_parse and fintd_emit.
module fins_tcp_frame_deframer_unit
   import fintd_pkg::*;
#(
   parameter int LEN_WIDTH = LenWidthDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   logic       take;
   logic       item_valid;
   req_type    item_data;
   logic       emit_ready;
   event_type  evt;
   header_type header;

   fintd_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .take       (take),
      .item_valid (item_valid),
      .item_data  (item_data)
   );

   fintd_parse #(
      .LEN_WIDTH (LEN_WIDTH)
   ) u_parse (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (item_valid),
      .item_data   (item_data),
      .emit_ready  (emit_ready),
      .take        (take),
      .evt         (evt),
      .header      (header),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   fintd_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .evt        (evt),
      .header     (header),
      .emit_ready (emit_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

### hw/rtl/fintd_in_stage.sv
// Input register of the deframer: holds one received item until the parser
// takes it. Depends on fintd_pkg.
module fintd_in_stage
   import fintd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   input  logic    take,
   output logic    item_valid,
   output req_type item_data
);

   logic    valid_ff;
   logic    valid_in;
   req_type data_ff;

   assign req_ready  = !valid_ff || take;
   assign valid_in   = req_ready ? req_valid : valid_ff;
   assign item_valid = valid_ff;
   assign item_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         data_ff <= req_data;
      end
   end

endmodule

### hw/rtl/fintd_parse.sv
// Frame parser: header collection, magic and length checks, payload count,
// discard until chunk end, and the maximum payload register.
// Depends on fintd_pkg.
module fintd_parse
   import fintd_pkg::*;
#(
   parameter int LEN_WIDTH = LenWidthDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        item_valid,
   input  req_type     item_data,
   input  logic        emit_ready,
   output logic        take,
   output event_type   evt,
   output header_type  header,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   typedef enum logic [1:0] {
      PH_COLLECT = 2'd0,
      PH_STREAM  = 2'd1,
      PH_DISCARD = 2'd2
   } phase_type;

   localparam logic [32:0] LenLimit = (33'd1 << LEN_WIDTH) - 33'd1;

   phase_type                   phase_ff, phase_in;
   logic [HeaderIdxWidth-1:0]   count_ff, count_in;
   logic [LEN_WIDTH-1:0]        left_ff, left_in;
   logic [LEN_WIDTH-1:0]        left_dec;
   logic [15:0]                 max_ff, max_in;
   header_type                  store_ff;
   logic                        store_we;
   logic [31:0]                 len;
   logic                        magic_ok;
   logic                        too_long;
   logic                        header_done;

   assign take     = item_valid && emit_ready;
   assign header   = store_ff;
   assign left_dec = left_ff - {{(LEN_WIDTH-1){1'b0}}, 1'b1};

   // The eighth byte is still on the input, so it joins the stored seven here.
   assign len = {store_ff[4], store_ff[5], store_ff[6], item_data.data_byte};
   assign magic_ok = (store_ff[0] == Magic0) && (store_ff[1] == Magic1) &&
                     (store_ff[2] == Magic2) && (store_ff[3] == Magic3);
   assign too_long = ({1'b0, len} > LenLimit) || (len > {16'd0, max_ff});
   assign header_done = (count_ff == HeaderIdxWidth'(HeaderBytes - 1));
   assign max_in = csr_wr_en ? csr_wr_data : max_ff;

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      left_in  = left_ff;
      store_we = 1'b0;
      evt      = '{kind: EV_NONE, data: 8'd0, last: 1'b0, error_kind: 1'b0};
      if (take) begin
         unique case (phase_ff)
            PH_DISCARD: begin
               if (item_data.chunk_end) begin
                  phase_in = PH_COLLECT;
                  count_in = '0;
               end
            end
            PH_STREAM: begin
               left_in    = left_dec;
               evt.kind   = EV_BYTE;
               evt.data   = item_data.data_byte;
               evt.last   = (left_dec == '0);
               if (left_dec == '0) begin
                  phase_in = PH_COLLECT;
               end
            end
            default: begin
               // Collecting the header; the spare phase code behaves the same.
               phase_in = PH_COLLECT;
               store_we = 1'b1;
               if (!header_done) begin
                  count_in = count_ff + 1'b1;
               end else begin
                  count_in = '0;
                  if (!magic_ok || too_long) begin
                     evt.kind       = EV_ERROR;
                     evt.error_kind = magic_ok ? ErrTooLong : ErrBadMagic;
                     phase_in       = item_data.chunk_end ? PH_COLLECT : PH_DISCARD;
                  end else begin
                     evt.kind = EV_HEADER;
                     evt.last = (len == 32'd0);
                     left_in  = len[LEN_WIDTH-1:0];
                     phase_in = (len == 32'd0) ? PH_COLLECT : PH_STREAM;
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_COLLECT;
         count_ff <= '0;
         left_ff  <= '0;
         max_ff   <= MaxPayloadReset;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         left_ff  <= left_in;
         max_ff   <= max_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         store_ff[count_ff] <= item_data.data_byte;
      end
   end

endmodule

### hw/rtl/fintd_emit.sv
// Output stage: result register and header replay. A good header is sent as
// eight items read back from the parser's header store. Depends on fintd_pkg.
module fintd_emit
   import fintd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  event_type  evt,
   input  header_type header,
   output logic       emit_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data
);

   logic                      valid_ff, valid_in;
   rsp_type                   rsp_ff, rsp_in;
   logic                      replay_ff, replay_in;
   logic [HeaderIdxWidth-1:0] idx_ff, idx_in;
   logic                      zero_len_ff, zero_len_in;
   logic                      free;

   assign free       = !valid_ff || rsp_ready;
   assign emit_ready = free && !replay_ff;
   assign rsp_valid  = valid_ff;
   assign rsp_data   = rsp_ff;

   always_comb begin
      valid_in    = valid_ff;
      rsp_in      = rsp_ff;
      replay_in   = replay_ff;
      idx_in      = idx_ff;
      zero_len_in = zero_len_ff;
      if (free) begin
         valid_in = 1'b0;
         if (replay_ff) begin
            valid_in = 1'b1;
            rsp_in   = '{out_byte: header[idx_ff],
                         frame_last: (idx_ff == HeaderIdxWidth'(HeaderBytes - 1)) &&
                                     zero_len_ff,
                         frame_error: 1'b0, error_kind: 1'b0};
            idx_in   = idx_ff + 1'b1;
            if (idx_ff == HeaderIdxWidth'(HeaderBytes - 1)) begin
               replay_in = 1'b0;
            end
         end else begin
            unique case (evt.kind)
               EV_BYTE: begin
                  valid_in = 1'b1;
                  rsp_in   = '{out_byte: evt.data, frame_last: evt.last,
                               frame_error: 1'b0, error_kind: 1'b0};
               end
               EV_ERROR: begin
                  valid_in = 1'b1;
                  rsp_in   = '{out_byte: 8'd0, frame_last: 1'b0,
                               frame_error: 1'b1, error_kind: evt.error_kind};
               end
               EV_HEADER: begin
                  valid_in    = 1'b1;
                  rsp_in      = '{out_byte: header[0], frame_last: 1'b0,
                                  frame_error: 1'b0, error_kind: 1'b0};
                  replay_in   = 1'b1;
                  idx_in      = HeaderIdxWidth'(1);
                  zero_len_in = evt.last;
               end
               EV_NONE: begin
                  valid_in = 1'b0;
               end
               default: begin
                  valid_in = 1'b0;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         replay_ff   <= 1'b0;
         idx_ff      <= '0;
         zero_len_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         replay_ff   <= replay_in;
         idx_ff      <= idx_in;
         zero_len_ff <= zero_len_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

endmodule

### hw/rtl/fintd_checker.sv
// Port-level checks for the deframer top level, attached by the bind below.
// Depends on fintd_pkg and fins_tcp_frame_deframer_unit.
module fintd_checker
   import fintd_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // After reset nothing is pending and an item can be taken.
   a_reset_idle : assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("deframer not idle after reset");

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result item changed while stalled");

   a_error_item : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.frame_error |-> rsp_data.out_byte == 8'd0 &&
                                            !rsp_data.frame_last)
      else $error("error item carries frame data");

   // Input back-pressure only comes from a full output register.
   a_stall_cause : assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input stalled with no result pending");

endmodule

bind fins_tcp_frame_deframer_unit fintd_checker u_fintd_checker (.*);
